[hw/rtl/lodd_pkg.sv]
// Package for the lock-order deadlock detector: item types, status codes,
// size constants. No dependencies.
`default_nettype none
package lodd_pkg;
   localparam int MaxLocks     = 16;
   localparam int MaxThreads   = 16;
   localparam int HistoryDepth = 16;

   localparam logic [1:0] CMD_LOCK   = 2'd0;
   localparam logic [1:0] CMD_UNLOCK = 2'd1;
   localparam logic [1:0] CMD_OTHER  = 2'd2;
   localparam logic [1:0] CMD_SPARE  = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_DEADLOCK    = 3'd1;
   localparam logic [2:0] ST_THREAD_FULL = 3'd2;
   localparam logic [2:0] ST_LOCK_FULL   = 3'd3;
   localparam logic [2:0] ST_HIST_FULL   = 3'd4;
   localparam logic [2:0] ST_UNKNOWN     = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] thread_id;
      logic [31:0] mutex_address;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] cycle_mask;
      logic [3:0]  thread_slot;
      logic [3:0]  lock_slot;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request
      logic tscan;    // step thread lookup
      logic decide;   // apply table update
      logic sinit;    // start search
      logic sstep;    // one search step
      logic finish;   // emit result
   } lodd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic tdone;
      logic do_search;
      logic sdone;
   } lodd_sts_type;
endpackage
`default_nettype wire

[hw/rtl/lodd_ctrl.sv]
// Controller state machine of the deadlock detector.
// Depends on lodd_pkg.
`default_nettype none
module lodd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire lodd_pkg::lodd_sts_type sts,
   output lodd_pkg::lodd_cmd_type     ctl
);
   import lodd_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_TSCAN = 3'd1, S_DECIDE = 3'd2,
                          S_SINIT = 3'd3, S_SSTEP = 3'd4, S_FIN = 3'd5;
   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: if (start) begin
            ctl.load = 1'b1;
            state_in = S_TSCAN;
         end
         S_TSCAN: begin
            ctl.tscan = 1'b1;
            if (sts.tdone) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ctl.decide = 1'b1;
            state_in = sts.do_search ? S_SINIT : S_FIN;
         end
         S_SINIT: begin
            ctl.sinit = 1'b1;
            state_in = S_SSTEP;
         end
         S_SSTEP: begin
            ctl.sstep = 1'b1;
            if (sts.sdone) state_in = S_FIN;
         end
         S_FIN: begin
            ctl.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

[hw/rtl/lodd_dp.sv]
// Datapath of the deadlock detector: thread, lock, history and edge tables
// plus the search engine. Depends on lodd_pkg.
`default_nettype none
module lodd_dp #(
   parameter int MAX_LOCKS     = lodd_pkg::MaxLocks,
   parameter int MAX_THREADS   = lodd_pkg::MaxThreads,
   parameter int HISTORY_DEPTH = lodd_pkg::HistoryDepth
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lodd_pkg::req_type     req_item,
   input  wire lodd_pkg::lodd_cmd_type ctl,
   output lodd_pkg::lodd_sts_type     sts,
   output logic                       rsp_valid,
   output lodd_pkg::rsp_type          rsp_item
);
   import lodd_pkg::*;
   localparam int LW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
   localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);
   localparam int DW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = $clog2(MAX_LOCKS + 2);
   localparam int HN = MAX_THREADS * HISTORY_DEPTH;
   localparam int HA = (HN > 1) ? $clog2(HN) : 1;

   req_type                       req_ff;
   logic [63:0]                   tid_ff [MAX_THREADS];
   logic [CW-1:0]                 tcount_ff;
   logic [TW-1:0]                 tscan_ff;
   logic [TW-1:0]                 tslot_ff;
   logic                          tfound_ff;
   logic [31:0]                   addr_ff [MAX_LOCKS];
   logic [MAX_LOCKS-1:0]          edge_ff [MAX_LOCKS];
   logic [DW-1:0]                 depth_ff [MAX_THREADS];
   logic [LW-1:0]                 hist_mem [HN];
   logic [LW-1:0]                 prev_rd_ff;
   logic [2:0]                    status_ff;
   logic [LW-1:0]                 lslot_ff;
   logic                          tfull_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;
   // search
   logic [LW-1:0]                 stk_ff [MAX_LOCKS+1];
   logic [LW:0]                   nxt_ff [MAX_LOCKS+1];
   logic [SW-1:0]                 sp_ff;
   logic [MAX_LOCKS-1:0]          visited_ff, path_ff;
   logic                          found_ff, sdone_ff;

   // thread scan: one slot per cycle
   logic tscan_hit, tscan_end;
   assign tscan_hit = (CW'(tscan_ff) < tcount_ff) &&
                      (tid_ff[tscan_ff] == req_ff.thread_id);
   assign tscan_end = tscan_hit || (CW'(tscan_ff) + CW'(1) >= tcount_ff) ||
                      (tcount_ff == '0);

   // lock lookup (parallel compare, MAX_LOCKS entries, 16 by default)
   logic            hit_a, hit_z;
   logic [LW-1:0]   idx_a, idx_z;
   always_comb begin
      hit_a = 1'b0; hit_z = 1'b0; idx_a = '0; idx_z = '0;
      for (int i = MAX_LOCKS - 1; i >= 0; i--) begin
         if (addr_ff[i] == req_ff.mutex_address) begin
            hit_a = 1'b1; idx_a = LW'(i);
         end
         if (addr_ff[i] == '0) begin
            hit_z = 1'b1; idx_z = LW'(i);
         end
      end
   end

   logic [TW-1:0] t_sel;
   logic          t_full;
   logic [DW-1:0] d_cur;
   assign t_full = !tfound_ff && (tcount_ff >= CW'(MAX_THREADS));
   assign t_sel  = tfound_ff ? tslot_ff : tcount_ff[TW-1:0];
   assign d_cur  = tfound_ff ? depth_ff[t_sel] : '0;

   logic do_lock, do_search;
   logic [LW-1:0] l_new;
   assign l_new = hit_a ? idx_a : idx_z;
   assign do_lock = !t_full && req_ff.cmd == CMD_LOCK && (hit_a || hit_z) &&
                    d_cur < DW'(HISTORY_DEPTH);
   assign do_search = do_lock && d_cur != '0;

   // history read address for the previous held lock (registered read)
   logic [HA-1:0] prev_addr;
   assign prev_addr = HA'(t_sel) * HA'(HISTORY_DEPTH) + HA'(d_cur) - HA'(1);

   // search step
   logic [LW-1:0] s_node;
   logic [LW:0]   s_i;
   logic [MAX_LOCKS-1:0] s_row;
   logic          s_has;
   logic [LW-1:0] s_succ;
   always_comb begin
      s_node = stk_ff[sp_ff - SW'(1)];
      s_i    = nxt_ff[sp_ff - SW'(1)];
      s_row  = edge_ff[s_node];
      s_has  = 1'b0; s_succ = '0;
      for (int j = MAX_LOCKS - 1; j >= 0; j--)
         if (s_row[j] && (LW+1)'(j) >= s_i) begin
            s_has = 1'b1; s_succ = LW'(j);
         end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff   <= req_item;
         tscan_ff <= '0;
         tfound_ff <= 1'b0;
      end
      if (ctl.tscan) begin
         if (tscan_hit) begin
            tfound_ff <= 1'b1; tslot_ff <= tscan_ff;
         end
         if (!tscan_end) tscan_ff <= tscan_ff + TW'(1);
         prev_rd_ff <= '0;
      end
      if (ctl.decide) begin
         tfull_ff <= t_full;
         lslot_ff <= '0;
         status_ff <= ST_OK;
         if (t_full) status_ff <= ST_THREAD_FULL;
         else begin
            if (!tfound_ff) tid_ff[t_sel] <= req_ff.thread_id;
            if (req_ff.cmd == CMD_LOCK) begin
               if (!(hit_a || hit_z)) status_ff <= ST_LOCK_FULL;
               else if (d_cur >= DW'(HISTORY_DEPTH)) status_ff <= ST_HIST_FULL;
               else begin
                  lslot_ff <= l_new;
                  if (!hit_a) addr_ff[l_new] <= req_ff.mutex_address;
                  hist_mem[HA'(t_sel) * HA'(HISTORY_DEPTH) + HA'(d_cur)] <= l_new;
               end
            end else if (req_ff.cmd == CMD_UNLOCK) begin
               if (!hit_a) status_ff <= ST_UNKNOWN;
               else begin
                  lslot_ff <= idx_a;
                  addr_ff[idx_a] <= '0;
                  for (int x = 0; x < MAX_LOCKS; x++)
                     edge_ff[x][idx_a] <= 1'b0;
                  edge_ff[idx_a] <= '0;
               end
            end
         end
      end
      if (do_search && ctl.decide) prev_rd_ff <= hist_mem[prev_addr];
      if (ctl.sinit) begin
         edge_ff[prev_rd_ff][lslot_ff] <= 1'b1;
         stk_ff[0] <= lslot_ff; nxt_ff[0] <= '0; sp_ff <= SW'(1);
         visited_ff <= MAX_LOCKS'(1) << lslot_ff;
         path_ff    <= MAX_LOCKS'(1) << lslot_ff;
         found_ff <= 1'b0; sdone_ff <= 1'b0;
      end
      if (ctl.sstep && !sdone_ff) begin
         if (!s_has) begin
            path_ff[s_node] <= 1'b0;
            sp_ff <= sp_ff - SW'(1);
            if (sp_ff == SW'(1)) sdone_ff <= 1'b1;
         end else begin
            nxt_ff[sp_ff - SW'(1)] <= (LW+1)'(s_succ) + (LW+1)'(1);
            if (!visited_ff[s_succ]) begin
               if (sp_ff >= SW'(MAX_LOCKS + 1)) begin
                  found_ff <= 1'b1; sdone_ff <= 1'b1;
               end else begin
                  visited_ff[s_succ] <= 1'b1; path_ff[s_succ] <= 1'b1;
                  stk_ff[sp_ff] <= s_succ; nxt_ff[sp_ff] <= '0;
                  sp_ff <= sp_ff + SW'(1);
               end
            end else if (path_ff[s_succ]) begin
               found_ff <= 1'b1; sdone_ff <= 1'b1;
            end
         end
      end
      if (ctl.decide) sdone_ff <= 1'b0;
      rsp_ff.status      <= (sdone_ff && found_ff) ? ST_DEADLOCK : status_ff;
      rsp_ff.cycle_mask  <= (sdone_ff && found_ff) ? 16'(path_ff) : 16'd0;
      rsp_ff.thread_slot <= tfull_ff ? 4'd0 : 4'(tslot_ff);
      rsp_ff.lock_slot   <= 4'(lslot_ff);
      if (ctl.decide && !t_full && !tfound_ff) tslot_ff <= t_sel;
      if (reset) begin
         tcount_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_LOCKS; i++) begin
            addr_ff[i] <= '0; edge_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_THREADS; i++) depth_ff[i] <= '0;
      end else begin
         rsp_valid_ff <= ctl.finish;
         if (ctl.decide && !t_full) begin
            if (!tfound_ff) tcount_ff <= tcount_ff + CW'(1);
            if (do_lock) depth_ff[t_sel] <= d_cur + DW'(1);
            else if (req_ff.cmd == CMD_UNLOCK && hit_a && d_cur != '0)
               depth_ff[t_sel] <= d_cur - DW'(1);
            else if (!tfound_ff) depth_ff[t_sel] <= '0;
         end
      end
   end

   assign sts.tdone     = tscan_end;
   assign sts.do_search = do_search;
   assign sts.sdone     = sdone_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_ff;
endmodule
`default_nettype wire

[hw/rtl/lock_order_deadlock_detector_unit.sv]
// Top level of the lock-order deadlock detector.
// Depends on lodd_pkg, lodd_ctrl and lodd_dp.
//
// One item at a time: raise start with req_item while busy is low. The
// item takes a thread lookup (one registered thread per cycle, up to
// MAX_THREADS), an update step, and for a lock that adds an order edge
// a depth-first search that does one edge test or pop per cycle. The result
// appears on rsp_item with rsp_valid high for one cycle; the receiver
// cannot stall, so it must take it then. busy drops as the result leaves.
`default_nettype none
module lock_order_deadlock_detector_unit #(
   parameter int MAX_LOCKS     = lodd_pkg::MaxLocks,
   parameter int MAX_THREADS   = lodd_pkg::MaxThreads,
   parameter int HISTORY_DEPTH = lodd_pkg::HistoryDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lodd_pkg::req_type req_item,
   output logic                   rsp_valid,
   output lodd_pkg::rsp_type      rsp_item
);
   import lodd_pkg::*;
   lodd_cmd_type ctl;
   lodd_sts_type sts;
   logic         busy_core;
   logic         start_core;

   // Drop start while the result is out, so an item is taken only when
   // busy is low.
   assign start_core = start && !rsp_valid;

   // Controller: sequence lookup, update, search and result.
   lodd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start_core), .busy(busy_core),
      .sts(sts), .ctl(ctl)
   );

   // Datapath: tables and search engine.
   lodd_dp #(
      .MAX_LOCKS(MAX_LOCKS), .MAX_THREADS(MAX_THREADS),
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_dp (
      .clock(clock), .reset(reset), .req_item(req_item), .ctl(ctl),
      .sts(sts), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   // Hold busy through the result cycle.
   assign busy = busy_core || rsp_valid;
endmodule
`default_nettype wire

[tb/lodd_checker.sv]
// Checker for the lock-order deadlock detector: mirrors the thread, lock and
// order-edge tables, predicts each result and compares. Depends on lodd_pkg.
`timescale 1ns / 100ps
module lodd_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire lodd_pkg::req_type req_item,
   input  wire logic              rsp_valid,
   input  wire lodd_pkg::rsp_type rsp_item,
   output int                     errors,
   output int                     pending
);
   import lodd_pkg::*;

   logic [31:0] lock_addr [MaxLocks];
   logic [63:0] thr_id [MaxThreads];
   int          thr_cnt;
   logic [3:0]  held [MaxThreads][HistoryDepth];
   int          held_depth [MaxThreads];
   logic [15:0] edges [MaxLocks];
   rsp_type     expected_rsps [$];

   function automatic int find_lock(logic [31:0] a);
      for (int i = 0; i < MaxLocks; i++)
         if (lock_addr[i] == a) return i;
      return -1;
   endfunction

   // depth-first search in ascending order; returns 1 on a cycle
   function automatic logic order_loop_seen(int first, output logic [15:0] path);
      int          stk [MaxLocks + 1];
      int          nxt [MaxLocks + 1];
      logic [15:0] seen;
      int          sp, node, i;
      seen = 0;
      path = 0;
      stk[0] = first; nxt[0] = 0; sp = 1;
      seen[first] = 1'b1; path[first] = 1'b1;
      while (sp > 0) begin
         node = stk[sp - 1];
         i = nxt[sp - 1];
         while (i < MaxLocks && !edges[node][i]) i++;
         if (i >= MaxLocks) begin
            path[node] = 1'b0;
            sp--;
         end else begin
            nxt[sp - 1] = i + 1;
            if (!seen[i]) begin
               if (sp >= MaxLocks + 1) return 1'b1;
               seen[i] = 1'b1; path[i] = 1'b1;
               stk[sp] = i; nxt[sp] = 0; sp++;
            end else if (path[i]) begin
               return 1'b1;
            end
         end
      end
      path = 0;
      return 1'b0;
   endfunction

   task automatic apply_event(input req_type r, output rsp_type o);
      int          t, l, ls, found, d, prev;
      logic        fresh;
      logic [15:0] m;
      o = '0;
      found = -1;
      t = 0; l = 0;
      for (int i = 0; i < thr_cnt; i++)
         if (thr_id[i] == r.thread_id) begin
            found = i;
            break;
         end
      if (found < 0 && thr_cnt >= MaxThreads) begin
         o.status = ST_THREAD_FULL;
      end else begin
         if (found < 0) begin
            t = thr_cnt;
            thr_id[t] = r.thread_id;
            thr_cnt++;
         end else begin
            t = found;
         end
         o.status = ST_OK;
         if (r.cmd == CMD_LOCK) begin
            ls = find_lock(r.mutex_address);
            fresh = 1'b0;
            if (ls < 0) begin
               ls = find_lock(32'd0);
               fresh = 1'b1;
            end
            if (ls < 0) begin
               o.status = ST_LOCK_FULL;
            end else if (held_depth[t] >= HistoryDepth) begin
               o.status = ST_HIST_FULL;
            end else begin
               l = ls;
               if (fresh) lock_addr[l] = r.mutex_address;
               d = held_depth[t];
               held[t][d] = l[3:0];
               d++;
               held_depth[t] = d;
               if (d > 1) begin
                  prev = held[t][d - 2];
                  edges[prev][l] = 1'b1;
                  if (order_loop_seen(l, m)) begin
                     o.status = ST_DEADLOCK;
                     o.cycle_mask = m;
                  end
               end
            end
         end else if (r.cmd == CMD_UNLOCK) begin
            ls = find_lock(r.mutex_address);
            if (ls < 0) begin
               o.status = ST_UNKNOWN;
            end else begin
               l = ls;
               lock_addr[l] = '0;
               edges[l] = '0;
               for (int x = 0; x < MaxLocks; x++) edges[x][l] = 1'b0;
               if (held_depth[t] != 0) held_depth[t]--;
            end
         end
      end
      if (o.status != ST_OK && o.status != ST_DEADLOCK) l = 0;
      o.thread_slot = t[3:0];
      o.lock_slot = l[3:0];
   endtask

   always @(posedge clock) begin
      rsp_type e, g;
      if (reset) begin
         errors <= 0;
         thr_cnt = 0;
         for (int i = 0; i < MaxLocks; i++) begin
            lock_addr[i] = '0;
            edges[i] = '0;
         end
         for (int i = 0; i < MaxThreads; i++) held_depth[i] = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("result with no item outstanding: %p", rsp_item);
               errors <= errors + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_item != e) begin
                  if (rsp_item.status != e.status)
                     $error("status: expected %0d, got %0d", e.status, rsp_item.status);
                  if (rsp_item.cycle_mask != e.cycle_mask)
                     $error("cycle_mask: expected %h, got %h", e.cycle_mask,
                            rsp_item.cycle_mask);
                  if (rsp_item.thread_slot != e.thread_slot)
                     $error("thread_slot: expected %0d, got %0d", e.thread_slot,
                            rsp_item.thread_slot);
                  if (rsp_item.lock_slot != e.lock_slot)
                     $error("lock_slot: expected %0d, got %0d", e.lock_slot,
                            rsp_item.lock_slot);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy) begin
            apply_event(req_item, g);
            expected_rsps.push_back(g);
         end
      end
      pending <= expected_rsps.size();
   end
endmodule

[tb/testbench.sv]
// Top of the deadlock detector testbench: clock, reset, stimulus, watchdog
// and verdict. Depends on lodd_pkg, lodd_checker and the unit under test.
`timescale 1ns / 100ps
module testbench;
   import lodd_pkg::*;

   localparam int IdleLimit = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      errors, pending;
   int      idle_cycles = 0;

   // pools of thread ids and mutex addresses the stimulus draws from
   logic [63:0] thread_pool [$];
   logic [31:0] mutex_pool [$];

   always #10 clock = ~clock;

   lock_order_deadlock_detector_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   lodd_checker check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .errors(errors), .pending(pending)
   );

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // hold start until the item is taken, then drop it
   task automatic send_item(input logic [1:0] cmd, input logic [63:0] tid,
                            input logic [31:0] addr);
      while (busy) @(negedge clock);
      start <= 1'b1;
      req_item <= '{cmd: cmd, thread_id: tid, mutex_address: addr};
      @(negedge clock);
      start <= 1'b0;
   endtask

   // mostly short gaps, a few long ones, many with none at all
   task automatic idle_gap();
      int n, r;
      r = $urandom_range(99);
      if (r < 50) n = 0;
      else if (r < 92) n = $urandom_range(3, 1);
      else n = $urandom_range(300, 20);
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_thread();
      logic [63:0] t;
      if (thread_pool.size() < 24 && $urandom_range(99) < 3) begin
         t = {$urandom, $urandom};
         thread_pool.push_back(t);
         return t;
      end
      return thread_pool[$urandom_range(thread_pool.size() - 1)];
   endfunction

   function automatic logic [31:0] pick_mutex();
      if ($urandom_range(99) < 2) return 32'd0;
      if ($urandom_range(99) < 3) return $urandom;
      return mutex_pool[$urandom_range(mutex_pool.size() - 1)];
   endfunction

   initial begin
      logic [63:0] tid, hog;
      logic [31:0] a;
      logic [1:0]  cmd;
      int          r;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extreme ids, other and unused commands, address zero
      send_item(CMD_OTHER, 64'h0, 32'h0);
      send_item(CMD_SPARE, '1, '1);
      send_item(CMD_LOCK, 64'h0, '1);
      send_item(CMD_LOCK, 64'h0, '1);          // relock: self edge
      send_item(CMD_UNLOCK, 64'h0, '1);
      send_item(CMD_UNLOCK, '1, 32'h1234);     // unknown mutex
      send_item(CMD_UNLOCK, '1, 32'h0);        // address zero, empty history
      send_item(CMD_LOCK, '1, 32'h0);          // address zero lock
      send_item(CMD_UNLOCK, '1, 32'h0);
      // two threads taking two mutexes in opposite order
      send_item(CMD_LOCK, 64'h11, 32'hA);
      send_item(CMD_LOCK, 64'h11, 32'hB);
      send_item(CMD_LOCK, 64'h22, 32'hB);
      send_item(CMD_LOCK, 64'h22, 32'hA);
      send_item(CMD_UNLOCK, 64'h11, 32'hA);
      send_item(CMD_UNLOCK, 64'h11, 32'hB);
      // fill one thread's history past its depth
      hog = 64'h5555_AAAA_5555_AAAA;
      repeat (HistoryDepth + 1) send_item(CMD_LOCK, hog, 32'hC0DE);
      send_item(CMD_UNLOCK, hog, 32'hC0DE);

      thread_pool = '{64'h0, '1, 64'h11, 64'h22};
      for (int i = 0; i < 20; i++) mutex_pool.push_back($urandom);

      // random: mostly lock runs with matching unlocks, some noise
      for (int n = 0; n < 1510; ) begin
         tid = pick_thread();
         r = $urandom_range(99);
         if (r < 70) begin
            // a short nest of locks then unlocks by one thread
            int k;
            logic [31:0] held_set [$];
            k = $urandom_range(4, 1);
            for (int j = 0; j < k; j++) begin
               a = pick_mutex();
               held_set.push_back(a);
               send_item(CMD_LOCK, tid, a);
               idle_gap();
               n++;
            end
            while (held_set.size() > 0) begin
               if ($urandom_range(99) < 20) break;   // leave some held
               a = held_set[$urandom_range(held_set.size() - 1)];
               send_item(CMD_UNLOCK, tid, a);
               idle_gap();
               n++;
               held_set.delete(0);
            end
         end else begin
            cmd = $urandom_range(3);
            send_item(cmd, tid, pick_mutex());
            idle_gap();
            n++;
         end
      end

      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
